/* src/first_unique_letter_tracker_assert.svh */
// Assertion macros shared by the first unique letter tracker RTL.
// No dependencies; included inside module bodies.
`ifndef FIRST_UNIQUE_LETTER_TRACKER_ASSERT_SVH
`define FIRST_UNIQUE_LETTER_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FLUT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FLUT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/flut_pkg.sv */
// Package for the first unique letter tracker: widths, command codes and types.
// No dependencies.
`timescale 1ns / 1ps

package flut_pkg;

    localparam int LETTER_W          = 5;
    localparam int ALPHABET_SIZE_DEF = 26;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_REMOVE
    } op_t;

    typedef struct packed {
        logic                start;
        op_t                 op;
        logic [LETTER_W-1:0] code;
    } cmd_t;

endpackage

/* src/flut_ifs.sv */
// Valid/ready stream interfaces for the input and result channels.
// Depends on flut_pkg.
`timescale 1ns / 1ps

interface flut_in_if;
    import flut_pkg::*;
    logic                valid;
    logic                ready;
    logic                start_req;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output start_req, output letter, input ready);
    modport sink   (input valid, input start_req, input letter, output ready);
endinterface

interface flut_out_if;
    import flut_pkg::*;
    logic                valid;
    logic                ready;
    logic                found;
    logic [LETTER_W-1:0] unique_letter;

    modport source (output valid, output found, output unique_letter, input ready);
    modport sink   (input valid, input found, input unique_letter, output ready);
endinterface

/* src/flut_front.sv */
// Front end: takes input transfers, keeps the seen marks, issues list commands.
// Depends on flut_pkg and flut_ifs.
`timescale 1ns / 1ps

module flut_front #(
    parameter int ALPHABET_SIZE = flut_pkg::ALPHABET_SIZE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    flut_in_if.sink       in_ch,
    output logic          push_valid,
    output flut_pkg::cmd_t push_cmd,
    input  logic          push_ready
);
    import flut_pkg::*;
    `include "first_unique_letter_tracker_assert.svh"

    localparam int IDX_W = $clog2(ALPHABET_SIZE);

    logic [ALPHABET_SIZE-1:0] seen_reg;
    logic [ALPHABET_SIZE-1:0] seen_next;
    logic [ALPHABET_SIZE-1:0] seen_base;
    logic [IDX_W-1:0]         idx;
    logic                     code_ok;
    logic                     in_fire;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign in_fire     = in_ch.valid && push_ready;

    assign code_ok = 32'(in_ch.letter) < 32'(ALPHABET_SIZE);
    assign idx     = IDX_W'(in_ch.letter);

    always_comb
    begin
        seen_base = in_ch.start_req ? '0 : seen_reg;
        seen_next = seen_base;
        push_cmd.start = in_ch.start_req;
        push_cmd.code  = in_ch.letter;
        push_cmd.op    = OP_NONE;
        if (code_ok)
        begin
            // first sighting appends; any later one removes (no-op if already gone)
            push_cmd.op    = seen_base[idx] ? OP_REMOVE : OP_APPEND;
            seen_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (in_fire)
            seen_reg <= seen_next;
    end

    `FLUT_ASSERT_NXT(a_start_clears, clk, rst_n, in_fire && in_ch.start_req,
        $countones(seen_reg) <= 1, "start left stale seen marks")
    `FLUT_ASSERT_IMP(a_append_unseen, clk, rst_n, in_fire && push_cmd.op == OP_APPEND,
        !seen_base[idx], "append issued for a letter already seen")
endmodule

/* src/flut_queue.sv */
// Short command queue decoupling the front end from the list back end.
// Depends on flut_pkg.
`timescale 1ns / 1ps

module flut_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  flut_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output flut_pkg::cmd_t pop_cmd,
    input  logic           pop_ready
);
    import flut_pkg::*;
    `include "first_unique_letter_tracker_assert.svh"

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `FLUT_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1,
        cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `FLUT_ASSERT_NXT(a_pop_only, clk, rst_n, pop && !push,
        cnt_reg == $past(cnt_reg) - 1'b1, "queue count lost a pop")
endmodule

/* src/flut_back.sv */
// Back end: compacting cell chain holding the ordered list of unique letters,
// plus the result register. Depends on flut_pkg and flut_ifs.
`timescale 1ns / 1ps

module flut_back #(
    parameter int ALPHABET_SIZE = flut_pkg::ALPHABET_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  flut_pkg::cmd_t cmd,
    output logic           cmd_ready,
    flut_out_if.source     out_ch
);
    import flut_pkg::*;
    `include "first_unique_letter_tracker_assert.svh"

    localparam int N = ALPHABET_SIZE;

    logic [N-1:0]        vld_reg;
    logic [N-1:0]        vld_next;
    logic [LETTER_W-1:0] dat_reg  [N];
    logic [LETTER_W-1:0] dat_next [N];
    logic [LETTER_W-1:0] dat_up   [N];
    logic [N-1:0]        base_v;
    logic [N-1:0]        prev_v;
    logic [N-1:0]        up_v;
    logic [N-1:0]        match;
    logic [N-1:0]        kill;
    logic                load;

    logic                out_vld_reg;
    logic                out_found_reg;
    logic [LETTER_W-1:0] out_letter_reg;

    assign load      = cmd_valid && (!out_vld_reg || out_ch.ready);
    assign cmd_ready = !out_vld_reg || out_ch.ready;

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.found         = out_found_reg;
    assign out_ch.unique_letter = out_letter_reg;

    // neighbor views of the chain
    always_comb
    begin
        base_v = cmd.start ? '0 : vld_reg;
        prev_v = {base_v[N-2:0], 1'b1};
        up_v   = {1'b0, base_v[N-1:1]};
        for (int i = 0; i < N - 1; i++)
            dat_up[i] = dat_reg[i + 1];
        dat_up[N-1] = dat_reg[N-1];
        for (int i = 0; i < N; i++)
            match[i] = base_v[i] && (dat_reg[i] == cmd.code);
        // cell i closes up when the match sits at or below it
        for (int i = 0; i < N; i++)
            kill[i] = |(match << (N - 1 - i));
    end

    always_comb
    begin
        vld_next = base_v;
        for (int i = 0; i < N; i++)
            dat_next[i] = dat_reg[i];
        unique case (cmd.op)
            OP_APPEND:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (!base_v[i] && prev_v[i])
                    begin
                        vld_next[i] = 1'b1;
                        dat_next[i] = cmd.code;
                    end
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (kill[i])
                    begin
                        vld_next[i] = up_v[i];
                        dat_next[i] = dat_up[i];
                    end
                end
            end
            default:
            begin
                vld_next = base_v;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
                vld_reg <= vld_next;
            if (load)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < N; i++)
                dat_reg[i] <= dat_next[i];
            out_found_reg  <= vld_next[0];
            out_letter_reg <= vld_next[0] ? dat_next[0] : '0;
        end
    end

    `FLUT_ASSERT_IMP(a_chain_compact, clk, rst_n, 1'b1,
        (vld_reg & (vld_reg + 1'b1)) == '0, "cell chain has a gap")
    `FLUT_ASSERT_NXT(a_head_reported, clk, rst_n, load,
        out_found_reg == vld_reg[0], "result does not match list head")
endmodule

/* src/first_unique_letter_tracker.sv */
// First unique letter tracker, top level: front end, command queue, back end.
// Depends on flut_pkg, flut_ifs, flut_front, flut_queue, flut_back.
`timescale 1ns / 1ps

// For each letter transfer on in_ch (code 0..25, start_req opens a new string
// and clears all history first) the block delivers exactly one result transfer
// on out_ch: found=1 with the oldest letter seen exactly once so far, or
// found=0 with unique_letter=0 when no such letter exists. Codes at or above
// ALPHABET_SIZE change nothing and just report the current oldest letter.
// Throughput is one letter per clock sustained while out_ch.ready stays high;
// the back end's cell chain applies one append or remove per cycle. A letter
// taken on in_ch is queued, then applied to the chain and the result register.
// A two-entry command queue sits between the seen-mark front end and the
// chain, so input stays open for up to two more transfers while a result
// waits for out_ch.ready.
// No clearing pass after reset: every valid bit and seen mark is a flip-flop
// cleared by rst_n; data registers are only read under their valid bits.

module first_unique_letter_tracker #(
    parameter int ALPHABET_SIZE = flut_pkg::ALPHABET_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    flut_in_if.sink    in_ch,
    flut_out_if.source out_ch
);
    import flut_pkg::*;

    // front end -> queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue -> back end
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // Classifies each letter against the seen marks: append, remove or nothing.
    flut_front #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .push_valid(push_valid),
        .push_cmd  (push_cmd),
        .push_ready(push_ready)
    );

    flut_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_cmd  (push_cmd),
        .push_ready(push_ready),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready)
    );

    // Holds the ordered list; a removal shifts every cell above the match down to close the gap.
    flut_back #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(pop_valid),
        .cmd      (pop_cmd),
        .cmd_ready(pop_ready),
        .out_ch   (out_ch)
    );
endmodule
